// ===== sv/ctld_pkg.sv =====
// Package for the terminal line discipline: result kinds, register indexes,
// reset values, special characters and the result record type.
// No dependencies; used by canonical_tty_line_discipline.
package ctld_pkg;

  // Default line buffer depth in bytes.
  localparam int LINE_BYTES_DEF = 512;

  // Field widths.
  localparam int KIND_W   = 4;
  localparam int BYTE_W   = 8;
  localparam int AMOUNT_W = 9;
  localparam int FLAGS_W  = 3;
  localparam int INDEX_W  = 3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ECHO    = 4'd0;
  localparam logic [KIND_W-1:0] KIND_ERASE   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_INTR    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_SUSP    = 4'd3;
  localparam logic [KIND_W-1:0] KIND_LINE    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_EOF     = 4'd5;
  localparam logic [KIND_W-1:0] KIND_DATA    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_NO_DATA = 4'd7;
  localparam logic [KIND_W-1:0] KIND_REFUSED = 4'd8;

  // Configuration register indexes.
  localparam logic [INDEX_W-1:0] REG_MODE_FLAGS = 3'd0;
  localparam logic [INDEX_W-1:0] REG_INTR_CHAR  = 3'd1;
  localparam logic [INDEX_W-1:0] REG_SUSP_CHAR  = 3'd2;
  localparam logic [INDEX_W-1:0] REG_ERASE_CHAR = 3'd3;
  localparam logic [INDEX_W-1:0] REG_KILL_CHAR  = 3'd4;
  localparam logic [INDEX_W-1:0] REG_EOF_CHAR   = 3'd5;
  localparam logic [INDEX_W-1:0] REG_EOL_CHAR   = 3'd6;

  // Mode flag bit positions.
  localparam int FLAG_SIG   = 0;
  localparam int FLAG_CANON = 1;
  localparam int FLAG_ECHO  = 2;

  // Register reset values.
  localparam logic [FLAGS_W-1:0] RST_MODE_FLAGS = 3'd7;
  localparam logic [BYTE_W-1:0]  RST_INTR_CHAR  = 8'd3;
  localparam logic [BYTE_W-1:0]  RST_SUSP_CHAR  = 8'd26;
  localparam logic [BYTE_W-1:0]  RST_ERASE_CHAR = 8'd8;
  localparam logic [BYTE_W-1:0]  RST_KILL_CHAR  = 8'd21;
  localparam logic [BYTE_W-1:0]  RST_EOF_CHAR   = 8'd4;
  localparam logic [BYTE_W-1:0]  RST_EOL_CHAR   = 8'd10;

  // Fixed special characters.
  localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
  localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_NL  = 8'h0A;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [AMOUNT_W-1:0] amount;
    logic                echo_on;
    logic                last;
  } res_t;

endpackage

// ===== sv/ctld_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the line buffer.
module ctld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/canonical_tty_line_discipline.sv =====
// Top level of the terminal line discipline: control state, line buffer RAM
// and the result queue. Depends on ctld_pkg and ctld_ram.
//
// The block takes one item (a received keyboard byte or a read request) in
// every cycle in which in_stall is low. Line length, read position and
// the line-ready flag sit in registers and are updated on acceptance; the
// line bytes sit in a RAM of LINE_BYTES entries with a registered read.
// Results pass the second stage, where read data is merged, and then a
// four-entry queue. An item may give up to two results while the output
// takes one per cycle, so in_stall rises when more than two results are
// already in flight; with the output free and one result per item the rate
// is one item per cycle. The buffer needs no clearing after reset.
// Configuration writes are always taken (cfg_ready is held high).
module canonical_tty_line_discipline #(
  parameter int LINE_BYTES = ctld_pkg::LINE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Item channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           mode,
  input  logic [ctld_pkg::BYTE_W-1:0]    rx_byte,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ctld_pkg::KIND_W-1:0]    kind,
  output logic [ctld_pkg::BYTE_W-1:0]    data_byte,
  output logic [ctld_pkg::AMOUNT_W-1:0]  amount,
  output logic                           echo_on,
  output logic                           last,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ctld_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [ctld_pkg::BYTE_W-1:0]    cfg_data
);

  localparam int ADDR_W = $clog2(LINE_BYTES);
  localparam int LEN_W  = $clog2(LINE_BYTES + 1);
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Configuration registers.
  logic [ctld_pkg::FLAGS_W-1:0] mode_flags;
  logic [ctld_pkg::BYTE_W-1:0]  intr_char;
  logic [ctld_pkg::BYTE_W-1:0]  susp_char;
  logic [ctld_pkg::BYTE_W-1:0]  erase_char;
  logic [ctld_pkg::BYTE_W-1:0]  kill_char;
  logic [ctld_pkg::BYTE_W-1:0]  eof_char;
  logic [ctld_pkg::BYTE_W-1:0]  eol_char;

  // Line state.
  logic [LEN_W-1:0] line_length;
  logic [LEN_W-1:0] line_length_next;
  logic [LEN_W-1:0] read_position;
  logic [LEN_W-1:0] read_position_next;
  logic             line_ready;
  logic             line_ready_next;

  // Decode stage outputs.
  logic                   accept;
  logic                   sig_en;
  logic                   canon;
  logic                   echo_en;
  logic [LEN_W-1:0]       len_inc;
  logic [LEN_W-1:0]       pos_inc;
  logic                   is_erase;
  logic                   ram_we;
  logic                   ram_re;
  logic [ctld_pkg::BYTE_W-1:0] ram_rdata;
  ctld_pkg::res_t         res0;
  ctld_pkg::res_t         res1;
  logic [1:0]             res_n;
  logic                   res_mem;

  // Second stage: results waiting for the RAM data.
  logic [1:0]             s1_n;
  logic                   s1_mem;
  ctld_pkg::res_t         s1_r0;
  ctld_pkg::res_t         s1_r1;
  ctld_pkg::res_t         s1_r0_fix;

  // Result queue.
  ctld_pkg::res_t         queue [QDEPTH];
  logic [QPTR_W-1:0]      wr_ptr;
  logic [QPTR_W-1:0]      rd_ptr;
  logic [QCNT_W-1:0]      q_count;
  logic                   pop;

  assign cfg_ready = 1'b1;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flags <= ctld_pkg::RST_MODE_FLAGS;
      intr_char  <= ctld_pkg::RST_INTR_CHAR;
      susp_char  <= ctld_pkg::RST_SUSP_CHAR;
      erase_char <= ctld_pkg::RST_ERASE_CHAR;
      kill_char  <= ctld_pkg::RST_KILL_CHAR;
      eof_char   <= ctld_pkg::RST_EOF_CHAR;
      eol_char   <= ctld_pkg::RST_EOL_CHAR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ctld_pkg::REG_MODE_FLAGS: mode_flags <= cfg_data[ctld_pkg::FLAGS_W-1:0];
        ctld_pkg::REG_INTR_CHAR:  intr_char  <= cfg_data;
        ctld_pkg::REG_SUSP_CHAR:  susp_char  <= cfg_data;
        ctld_pkg::REG_ERASE_CHAR: erase_char <= cfg_data;
        ctld_pkg::REG_KILL_CHAR:  kill_char  <= cfg_data;
        ctld_pkg::REG_EOF_CHAR:   eof_char   <= cfg_data;
        ctld_pkg::REG_EOL_CHAR:   eol_char   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold off new items when more than two results are already in flight, so
  // the queue always has room for what the second stage and the new item give.
  assign in_stall = ({1'b0, q_count} + {2'b00, s1_n}) > 4'd2;
  assign accept   = in_valid && !in_stall;

  assign sig_en   = mode_flags[ctld_pkg::FLAG_SIG];
  assign canon    = mode_flags[ctld_pkg::FLAG_CANON];
  assign echo_en  = mode_flags[ctld_pkg::FLAG_ECHO];
  assign len_inc  = line_length + LEN_W'(1);
  assign pos_inc  = read_position + LEN_W'(1);
  assign is_erase = (rx_byte == erase_char) || (rx_byte == ctld_pkg::CH_BS) ||
                    (rx_byte == ctld_pkg::CH_DEL);

  // Decode one item: next line state, buffer access and its results.
  always_comb begin
    line_length_next   = line_length;
    read_position_next = read_position;
    line_ready_next    = line_ready;
    ram_we             = 1'b0;
    ram_re             = 1'b0;
    res0               = '0;
    res1               = '0;
    res_n              = 2'd0;
    res_mem            = 1'b0;
    res0.last          = 1'b1;
    res1.last          = 1'b1;

    if (mode) begin
      // Read one byte of the line.
      res0.kind = ctld_pkg::KIND_NO_DATA;
      res_n     = 2'd1;
      if (canon && !line_ready) begin
        res0.kind = ctld_pkg::KIND_NO_DATA;
      end else if (read_position >= line_length ||
                   read_position >= LEN_W'(LINE_BYTES)) begin
        if (line_ready) begin
          line_length_next   = '0;
          read_position_next = '0;
          line_ready_next    = 1'b0;
        end
      end else begin
        ram_re             = 1'b1;
        res_mem            = 1'b1;
        res0.kind          = ctld_pkg::KIND_DATA;
        res0.last          = pos_inc >= line_length;
        read_position_next = pos_inc;
        if (pos_inc >= line_length) begin
          line_length_next   = '0;
          read_position_next = '0;
          line_ready_next    = 1'b0;
        end
      end
    end else if (line_ready) begin
      // A finished line is still being drained.
      res0.kind = ctld_pkg::KIND_REFUSED;
      res_n     = 2'd1;
    end else if (sig_en && rx_byte == intr_char) begin
      res0.kind    = ctld_pkg::KIND_INTR;
      res0.echo_on = echo_en;
      res_n        = 2'd1;
    end else if (sig_en && rx_byte == susp_char) begin
      res0.kind    = ctld_pkg::KIND_SUSP;
      res0.echo_on = echo_en;
      res_n        = 2'd1;
    end else if (!canon) begin
      // Raw input: store and echo at once.
      if (line_length >= LEN_W'(LINE_BYTES - 1)) begin
        res0.kind = ctld_pkg::KIND_REFUSED;
        res_n     = 2'd1;
      end else begin
        ram_we           = 1'b1;
        line_length_next = len_inc;
        if (echo_en) begin
          res_n = 2'd1;
          if (rx_byte == ctld_pkg::CH_BS || rx_byte == ctld_pkg::CH_DEL) begin
            res0.kind   = ctld_pkg::KIND_ERASE;
            res0.amount = ctld_pkg::AMOUNT_W'(1);
          end else begin
            res0.kind      = ctld_pkg::KIND_ECHO;
            res0.data_byte = rx_byte;
          end
        end
      end
    end else if (is_erase) begin
      if (line_length != '0) begin
        line_length_next = line_length - LEN_W'(1);
        if (echo_en) begin
          res0.kind   = ctld_pkg::KIND_ERASE;
          res0.amount = ctld_pkg::AMOUNT_W'(1);
          res_n       = 2'd1;
        end
      end
    end else if (rx_byte == kill_char) begin
      line_length_next = '0;
      if (line_length != '0 && echo_en) begin
        res0.kind   = ctld_pkg::KIND_ERASE;
        res0.amount = ctld_pkg::AMOUNT_W'(line_length);
        res_n       = 2'd1;
      end
    end else if (rx_byte == eof_char) begin
      res_n = 2'd1;
      if (line_length == '0) begin
        res0.kind = ctld_pkg::KIND_EOF;
      end else begin
        line_ready_next    = 1'b1;
        read_position_next = '0;
        res0.kind          = ctld_pkg::KIND_LINE;
        res0.amount        = ctld_pkg::AMOUNT_W'(line_length);
      end
    end else begin
      // Ordinary byte: store it and check for line completion.
      ram_we           = line_length < LEN_W'(LINE_BYTES);
      line_length_next = len_inc;
      if (rx_byte == ctld_pkg::CH_NL || rx_byte == eol_char ||
          len_inc >= LEN_W'(LINE_BYTES - 1)) begin
        line_ready_next    = 1'b1;
        read_position_next = '0;
        if (echo_en) begin
          res0.kind      = ctld_pkg::KIND_ECHO;
          res0.data_byte = rx_byte;
          res0.last      = 1'b0;
          res1.kind      = ctld_pkg::KIND_LINE;
          res1.amount    = ctld_pkg::AMOUNT_W'(len_inc);
          res_n          = 2'd2;
        end else begin
          res0.kind   = ctld_pkg::KIND_LINE;
          res0.amount = ctld_pkg::AMOUNT_W'(len_inc);
          res_n       = 2'd1;
        end
      end else if (echo_en) begin
        res0.kind      = ctld_pkg::KIND_ECHO;
        res0.data_byte = rx_byte;
        res_n          = 2'd1;
      end
    end
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length   <= '0;
      read_position <= '0;
      line_ready    <= 1'b0;
    end else if (accept) begin
      line_length   <= line_length_next;
      read_position <= read_position_next;
      line_ready    <= line_ready_next;
    end
  end

  // Line buffer. A write lands before any later read issues, so no bypass.
  ctld_ram #(
    .WIDTH (ctld_pkg::BYTE_W),
    .DEPTH (LINE_BYTES)
  ) u_line_ram (
    .clk   (clk),
    .we    (accept && ram_we),
    .waddr (line_length[ADDR_W-1:0]),
    .wdata (rx_byte),
    .re    (accept && ram_re),
    .raddr (read_position[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Second stage: hold the results while the RAM read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_n <= 2'd0;
    end else begin
      s1_n <= accept ? res_n : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r0  <= res0;
      s1_r1  <= res1;
      s1_mem <= res_mem;
    end
  end

  // Merge the byte read from the buffer into a read result.
  always_comb begin
    s1_r0_fix = s1_r0;
    if (s1_mem) begin
      s1_r0_fix.data_byte = ram_rdata;
    end
  end

  // Result queue: up to two pushes and one pop per cycle.
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (s1_n != 2'd0) begin
      queue[wr_ptr] <= s1_r0_fix;
    end
    if (s1_n == 2'd2) begin
      queue[wr_ptr + QPTR_W'(1)] <= s1_r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + QPTR_W'(s1_n);
      rd_ptr  <= rd_ptr + QPTR_W'(pop);
      q_count <= q_count + QCNT_W'(s1_n) - QCNT_W'(pop);
    end
  end

  // Result channel.
  assign out_valid = q_count != '0;
  assign kind      = queue[rd_ptr].kind;
  assign data_byte = queue[rd_ptr].data_byte;
  assign amount    = queue[rd_ptr].amount;
  assign echo_on   = queue[rd_ptr].echo_on;
  assign last      = queue[rd_ptr].last;

endmodule

// ===== bench/canonical_tty_line_discipline_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for canonical_tty_line_discipline: directed and random keyboard
// traffic, with an independent line-discipline predictor and an in-order result checker.
// Depends on ctld_pkg and the block under test.
module canonical_tty_line_discipline_test;
  import ctld_pkg::*;

  localparam int LINE_MAX = LINE_BYTES_DEF;
  localparam logic [INDEX_W-1:0] REG_SPARE = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = 1'b0;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] data_byte;
  logic [AMOUNT_W-1:0] amount;
  logic echo_on;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0] cfg_data = '0;

  canonical_tty_line_discipline dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .data_byte(data_byte),
    .amount(amount), .echo_on(echo_on), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the terminal settings.
  logic [FLAGS_W-1:0] tty_flags = RST_MODE_FLAGS;
  logic [BYTE_W-1:0] intr_ch = RST_INTR_CHAR;
  logic [BYTE_W-1:0] susp_ch = RST_SUSP_CHAR;
  logic [BYTE_W-1:0] erase_ch = RST_ERASE_CHAR;
  logic [BYTE_W-1:0] kill_ch = RST_KILL_CHAR;
  logic [BYTE_W-1:0] eof_ch = RST_EOF_CHAR;
  logic [BYTE_W-1:0] eol_ch = RST_EOL_CHAR;

  // Shadow of the line buffer and its pointers.
  logic [BYTE_W-1:0] line_copy [LINE_MAX];
  logic [9:0] line_len = '0;
  logic [9:0] read_pos = '0;
  logic line_pending = 1'b0;

  // Reports still due from the block, oldest first.
  res_t awaited[$];
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  bit idle_on = 1'b1;
  int sink_hold_req = 0;

  function automatic void await_report(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] d,
                                       logic [AMOUNT_W-1:0] n, logic e, logic l);
    res_t r;
    r.kind = k;
    r.data_byte = d;
    r.amount = n;
    r.echo_on = e;
    r.last = l;
    awaited.push_back(r);
  endfunction

  function automatic void drop_line();
    line_len = '0;
    read_pos = '0;
    line_pending = 1'b0;
  endfunction

  // Works out the reports caused by one received keyboard byte.
  function automatic void predict_keystroke(logic [BYTE_W-1:0] c);
    logic sig, canon, echo;
    sig = tty_flags[FLAG_SIG];
    canon = tty_flags[FLAG_CANON];
    echo = tty_flags[FLAG_ECHO];
    if (line_pending) begin
      await_report(KIND_REFUSED, '0, '0, 1'b0, 1'b1);
      return;
    end
    if (sig && c == intr_ch) begin
      await_report(KIND_INTR, '0, '0, echo, 1'b1);
      return;
    end
    if (sig && c == susp_ch) begin
      await_report(KIND_SUSP, '0, '0, echo, 1'b1);
      return;
    end
    // Raw mode: a byte is stored and readable at once unless the buffer is full.
    if (!canon) begin
      if (line_len >= LINE_MAX - 1) begin
        await_report(KIND_REFUSED, '0, '0, 1'b0, 1'b1);
        return;
      end
      line_copy[line_len[8:0]] = c;
      line_len++;
      if (echo) begin
        if (c == CH_BS || c == CH_DEL) await_report(KIND_ERASE, '0, 9'd1, 1'b0, 1'b1);
        else await_report(KIND_ECHO, c, '0, 1'b0, 1'b1);
      end
      return;
    end
    // Line editing characters.
    if (c == erase_ch || c == CH_BS || c == CH_DEL) begin
      if (line_len != 0) begin
        line_len--;
        if (echo) await_report(KIND_ERASE, '0, 9'd1, 1'b0, 1'b1);
      end
      return;
    end
    if (c == kill_ch) begin
      if (line_len != 0 && echo) await_report(KIND_ERASE, '0, line_len[8:0], 1'b0, 1'b1);
      line_len = '0;
      return;
    end
    if (c == eof_ch) begin
      if (line_len == 0) begin
        await_report(KIND_EOF, '0, '0, 1'b0, 1'b1);
      end else begin
        line_pending = 1'b1;
        read_pos = '0;
        await_report(KIND_LINE, '0, line_len[8:0], 1'b0, 1'b1);
      end
      return;
    end
    // Ordinary byte: store it, and finish the line on a terminator or when full.
    if (line_len < LINE_MAX) line_copy[line_len[8:0]] = c;
    line_len++;
    if (c == CH_NL || c == eol_ch || line_len >= LINE_MAX - 1) begin
      line_pending = 1'b1;
      read_pos = '0;
      if (echo) await_report(KIND_ECHO, c, '0, 1'b0, 1'b0);
      await_report(KIND_LINE, '0, line_len[8:0], 1'b0, 1'b1);
    end else if (echo) begin
      await_report(KIND_ECHO, c, '0, 1'b0, 1'b1);
    end
  endfunction

  // Works out the report for one read request.
  function automatic void predict_read();
    logic [BYTE_W-1:0] b;
    logic done;
    if (tty_flags[FLAG_CANON] && !line_pending) begin
      await_report(KIND_NO_DATA, '0, '0, 1'b0, 1'b1);
      return;
    end
    if (read_pos >= line_len || read_pos >= LINE_MAX) begin
      if (line_pending) drop_line();
      await_report(KIND_NO_DATA, '0, '0, 1'b0, 1'b1);
      return;
    end
    b = line_copy[read_pos[8:0]];
    read_pos++;
    done = (read_pos >= line_len);
    if (done) drop_line();
    await_report(KIND_DATA, b, '0, 1'b0, done);
  endfunction

  // Mostly no gap, sometimes a short one and now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one item and updates the predictor once the transaction completes.
  task automatic send_item(logic m, logic [BYTE_W-1:0] b);
    int gap;
    gap = idle_on ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (m) predict_read();
    else predict_keystroke(b);
  endtask

  // Stops offering items and waits until every report is in and the pipeline is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // One register write transaction; only called while the block is idle.
  task automatic write_reg(logic [INDEX_W-1:0] idx, logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MODE_FLAGS: tty_flags = val[FLAGS_W-1:0];
      REG_INTR_CHAR: intr_ch = val;
      REG_SUSP_CHAR: susp_ch = val;
      REG_ERASE_CHAR: erase_ch = val;
      REG_KILL_CHAR: kill_ch = val;
      REG_EOF_CHAR: eof_ch = val;
      REG_EOL_CHAR: eol_ch = val;
      default: ;
    endcase
  endtask

  // Mode flags with random junk in the unused upper bits.
  function automatic logic [BYTE_W-1:0] flag_byte(logic [FLAGS_W-1:0] f);
    logic [4:0] hi;
    hi = 5'($urandom_range(0, 31));
    return {hi, f};
  endfunction

  task automatic set_flags(logic [FLAGS_W-1:0] f);
    wait_idle();
    write_reg(REG_MODE_FLAGS, flag_byte(f));
  endtask

  task automatic write_all(logic [FLAGS_W-1:0] f, logic [BYTE_W-1:0] c_intr,
                           logic [BYTE_W-1:0] c_susp, logic [BYTE_W-1:0] c_erase,
                           logic [BYTE_W-1:0] c_kill, logic [BYTE_W-1:0] c_eof,
                           logic [BYTE_W-1:0] c_eol);
    write_reg(REG_MODE_FLAGS, flag_byte(f));
    write_reg(REG_INTR_CHAR, c_intr);
    write_reg(REG_SUSP_CHAR, c_susp);
    write_reg(REG_ERASE_CHAR, c_erase);
    write_reg(REG_KILL_CHAR, c_kill);
    write_reg(REG_EOF_CHAR, c_eof);
    write_reg(REG_EOL_CHAR, c_eol);
  endtask

  // A byte that none of the current settings treat specially.
  function automatic logic [BYTE_W-1:0] plain_char();
    logic [BYTE_W-1:0] b;
    do begin
      b = BYTE_W'($urandom_range(0, 255));
    end while (b == intr_ch || b == susp_ch || b == erase_ch || b == kill_ch ||
               b == eof_ch || b == eol_ch || b == CH_BS || b == CH_DEL || b == CH_NL);
    return b;
  endfunction

  // Mostly random bytes, with the control characters mixed in.
  function automatic logic [BYTE_W-1:0] pick_key();
    case ($urandom_range(0, 19))
      0: return intr_ch;
      1: return susp_ch;
      2: return erase_ch;
      3: return CH_BS;
      4: return CH_DEL;
      5: return kill_ch;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] rand_char();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Editing, signals, line completion and draining under the reset settings.
  task automatic test_reset_defaults();
    send_item(1'b0, "h");
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, CH_BS);
    send_item(1'b0, CH_DEL);
    send_item(1'b0, RST_ERASE_CHAR);
    send_item(1'b0, CH_DEL);
    send_item(1'b0, "a");
    send_item(1'b0, "b");
    send_item(1'b0, RST_KILL_CHAR);
    send_item(1'b0, RST_KILL_CHAR);
    send_item(1'b0, RST_EOF_CHAR);
    send_item(1'b0, RST_INTR_CHAR);
    send_item(1'b0, RST_SUSP_CHAR);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, "x");
    send_item(1'b0, "y");
    send_item(1'b0, RST_EOF_CHAR);
    send_item(1'b0, "z");
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'h55);
    send_item(1'b1, 8'hAA);
    send_item(1'b0, "q");
    send_item(1'b0, CH_NL);
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'h00);
  endtask

  // Every register rewritten, raw mode, disabled signals and echo, and mode switches.
  task automatic test_register_writes();
    wait_idle();
    write_all(3'd5, 8'h00, 8'hFF, "A", "B", "C", ".");
    write_reg(REG_SPARE, 8'h5A);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, "A");
    send_item(1'b0, CH_BS);
    send_item(1'b0, CH_DEL);
    repeat (4) send_item(1'b1, 8'h00);
    set_flags(3'd3);
    send_item(1'b0, "m");
    send_item(1'b0, "B");
    send_item(1'b0, "n");
    send_item(1'b0, ".");
    repeat (2) send_item(1'b1, 8'h00);
    set_flags(3'd1);
    send_item(1'b0, "k");
    send_item(1'b1, 8'h00);
    set_flags(3'd0);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    // A partial canonical line stays in the buffer and becomes readable in raw mode.
    set_flags(3'd7);
    send_item(1'b0, "p");
    send_item(1'b0, "r");
    set_flags(3'd5);
    repeat (5) send_item(1'b1, 8'h00);
    wait_idle();
    write_all(RST_MODE_FLAGS, RST_INTR_CHAR, RST_SUSP_CHAR, RST_ERASE_CHAR,
              RST_KILL_CHAR, RST_EOF_CHAR, RST_EOL_CHAR);
  endtask

  // The receiver holds off while the sender keeps going, then the sender waits for
  // every report.
  task automatic test_backpressure();
    int k;
    wait_idle();
    idle_on = 1'b0;
    sink_hold_req = 80;
    repeat (4) begin
      for (k = 0; k < 7; k++) send_item(1'b0, plain_char());
      send_item(1'b0, CH_NL);
      repeat (8) send_item(1'b1, BYTE_W'($urandom_range(0, 255)));
    end
    wait_idle();
    idle_on = 1'b1;
  endtask

  // Full buffer in raw mode, then completion past the size limit with a wrapped line
  // length. The finished line is left pending, so this test comes last.
  task automatic test_long_lines();
    int k;
    set_flags(3'd4);
    // Drain any line left pending by earlier traffic.
    while (line_pending) send_item(1'b1, 8'h00);
    for (k = 0; k < LINE_MAX; k++) send_item(1'b0, BYTE_W'($urandom_range(0, 255)));
    set_flags(3'd6);
    send_item(1'b0, plain_char());
    for (k = 0; k < 8; k++) send_item(1'b1, BYTE_W'($urandom_range(0, 255)));
    send_item(1'b0, plain_char());
  endtask

  // Random lines with editing, terminators and reads under several settings.
  task automatic type_line();
    int len, k, extra;
    logic [BYTE_W-1:0] stop;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 60) : $urandom_range(0, 10);
    extra = $urandom_range(0, 2);
    for (k = 0; k < len; k++) send_item(1'b0, pick_key());
    case ($urandom_range(0, 2))
      0: stop = CH_NL;
      1: stop = eol_ch;
      default: stop = eof_ch;
    endcase
    send_item(1'b0, stop);
    for (k = 0; k < len + extra; k++) send_item(1'b1, BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic test_random_traffic();
    int phase;
    int unsigned first;
    logic [FLAGS_W-1:0] f;
    for (phase = 0; phase < 8; phase++) begin
      wait_idle();
      f = FLAGS_W'($urandom_range(0, 7));
      if ($urandom_range(0, 2) != 0) f[FLAG_CANON] = 1'b1;
      case (phase)
        0: write_all(RST_MODE_FLAGS, RST_INTR_CHAR, RST_SUSP_CHAR, RST_ERASE_CHAR,
                     RST_KILL_CHAR, RST_EOF_CHAR, RST_EOL_CHAR);
        1: write_all(3'd7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        2: write_all(3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        default: write_all(f, rand_char(), rand_char(), rand_char(), rand_char(),
                           rand_char(), rand_char());
      endcase
      // One phase runs without any idling on either side.
      idle_on = (phase != 3);
      first = items_sent;
      while (items_sent - first < 25) begin
        if ($urandom_range(0, 9) < 7) begin
          type_line();
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_item(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
          end
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // Receiver stalls: random gaps, plus a long counted hold when a test asks for one.
  initial begin : sink_stalls
    int len;
    forever begin
      @(posedge clk);
      if (sink_hold_req != 0) begin
        len = sink_hold_req;
        sink_hold_req = 0;
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        len = gap_len();
        if (len != 0) begin
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Each result transaction is compared with the oldest awaited report.
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        $error("unexpected result: kind %0d data_byte %0h amount %0d", kind, data_byte,
               amount);
        fail_count++;
      end else begin
        want = awaited.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          fail_count++;
        end
        if (data_byte !== want.data_byte) begin
          $error("data_byte: expected %0h, got %0h", want.data_byte, data_byte);
          fail_count++;
        end
        if (amount !== want.amount) begin
          $error("amount: expected %0d, got %0d", want.amount, amount);
          fail_count++;
        end
        if (echo_on !== want.echo_on) begin
          $error("echo_on: expected %0b, got %0b", want.echo_on, echo_on);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          fail_count++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #(12 * 2_000_000);
    $display("TB_ERROR");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_writes();
    test_backpressure();
    test_random_traffic();
    test_long_lines();
    wait_idle();
    if (fail_count == 0 && awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
